>>> rtl/core/mds_pkg.sv
package mds_pkg;

   // Default widths of the fixed-point fraction and of the run site counter.
   localparam int FRAC_BITS_DEF  = 16;
   localparam int COUNT_BITS_DEF = 20;

   // Field widths of the request and response items.
   localparam int CHROM_W     = 8;
   localparam int POS_W       = 32;
   localparam int READS_W     = 16;
   localparam int CLASS_W     = 2;
   localparam int STOP_W      = 33;
   localparam int OUT_COUNT_W = 20;
   localparam int SCORE_W     = 37;

   // Largest site count that a response can carry.
   localparam int OUT_COUNT_MAX = (2 ** OUT_COUNT_W) - 1;

   // Depth of the queues between the stages and at the response side.
   localparam int QUEUE_DEPTH = 4;

   // Register port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 37;
   localparam logic [CSR_INDEX_W-1:0] CSR_DESERT_LEN = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_SCORE  = 1'b1;

   localparam logic [POS_W-1:0]   DESERT_RESET    = 32'd1000;
   localparam logic [SCORE_W-1:0] MIN_SCORE_RESET = 37'd262144;

   // Decoded class code of the hypo group; every other code is the hyper group.
   localparam logic [CLASS_W-1:0] CLASS_HYPO = 2'd0;

   // States of the front-end sequencer.
   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_DIVIDE,
      FRONT_ISSUE
   } mds_front_state_type;

   // One emitted domain.
   typedef struct packed {
      logic [CHROM_W-1:0]     out_chrom;
      logic [POS_W-1:0]       start_pos;
      logic [STOP_W-1:0]      stop_pos;
      logic [OUT_COUNT_W-1:0] site_count;
      logic [SCORE_W-1:0]     score;
      logic                   last_of_run;
   } mds_result_type;

endpackage

>>> rtl/core/mds_queue.sv
// Small first-in first-out queue with two write slots per cycle. It reports
// full while fewer than two entries are free, so a writer that checks full
// may always store up to two entries.
module mds_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_a,
   input  logic [WIDTH-1:0] data_a,
   input  logic             push_b,
   input  logic [WIDTH-1:0] data_b,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic             empty,
   output logic             full
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_ptr_b;
   logic             pop_ok;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff > CNT_W'(DEPTH - 2));
   assign head     = entry_ff[rd_ptr_ff];
   assign pop_ok   = pop && !empty;
   assign wr_ptr_b = wr_ptr_ff + 1'b1;

   // Pointer and fill level updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_a) + PTR_W'(push_b);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop_ok);
      count_in  = count_ff + CNT_W'(push_a) + CNT_W'(push_b) - CNT_W'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage; the second slot lands right after the first.
   always_ff @(posedge clock) begin
      if (push_a) begin
         entry_ff[wr_ptr_ff] <= data_a;
      end
      if (push_b) begin
         entry_ff[wr_ptr_b] <= data_b;
      end
   end

endmodule

>>> rtl/core/mds_front.sv
// Front end: takes one site request, drops the read-count test into a valid
// flag, decodes the class group and works out the methylation fraction with
// a restoring divider that produces one quotient bit per cycle.
module mds_front import mds_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [CHROM_W-1:0]   req_chrom_id,
   input  logic [POS_W-1:0]     req_site_pos,
   input  logic [READS_W-1:0]   req_total_reads,
   input  logic [READS_W-1:0]   req_meth_reads,
   input  logic [CLASS_W-1:0]   req_site_class,
   input  logic                 req_end_of_stream,
   output logic                 issue_push,
   input  logic                 issue_full,
   output logic                 issue_site_valid,
   output logic [CHROM_W-1:0]   issue_chrom,
   output logic [POS_W-1:0]     issue_pos,
   output logic [FRAC_BITS:0]   issue_frac,
   output logic                 issue_hyper,
   output logic                 issue_eos
);

   localparam int STEP_W = $clog2(FRAC_BITS);

   mds_front_state_type state_ff, state_in;

   logic [CHROM_W-1:0]   chrom_ff, chrom_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [READS_W-1:0]   total_ff, total_in;
   logic [READS_W-1:0]   rem_ff, rem_in;
   logic [FRAC_BITS-1:0] quot_ff, quot_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 valid_ff, valid_in;
   logic                 whole_ff, whole_in;
   logic                 hyper_ff, hyper_in;
   logic                 eos_ff, eos_in;
   logic                 accept;
   logic                 no_divide;
   logic [READS_W:0]     rem_shift;
   logic                 rem_ge;

   assign accept    = req_push && !req_full;
   assign no_divide = (req_total_reads == '0) || (req_meth_reads >= req_total_reads);
   assign rem_shift = {rem_ff, 1'b0};
   assign rem_ge    = (rem_shift >= {1'b0, total_ff});

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FRONT_IDLE: begin
            if (req_push) begin
               state_in = no_divide ? FRONT_ISSUE : FRONT_DIVIDE;
            end
         end
         FRONT_DIVIDE: begin
            if (step_ff == '0) begin
               state_in = FRONT_ISSUE;
            end
         end
         FRONT_ISSUE: begin
            if (!issue_full) begin
               state_in = FRONT_IDLE;
            end
         end
         default: state_in = FRONT_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_full   = 1'b1;
      issue_push = 1'b0;
      unique case (state_ff)
         FRONT_IDLE:   req_full   = 1'b0;
         FRONT_DIVIDE: req_full   = 1'b1;
         FRONT_ISSUE:  issue_push = !issue_full;
         default:      req_full   = 1'b1;
      endcase
   end

   // Capture of the request and one divider step per cycle.
   always_comb begin
      chrom_in = chrom_ff;
      pos_in   = pos_ff;
      total_in = total_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      step_in  = step_ff;
      valid_in = valid_ff;
      whole_in = whole_ff;
      hyper_in = hyper_ff;
      eos_in   = eos_ff;
      if (accept) begin
         chrom_in = req_chrom_id;
         pos_in   = req_site_pos;
         total_in = req_total_reads;
         rem_in   = req_meth_reads;
         quot_in  = '0;
         step_in  = STEP_W'(FRAC_BITS - 1);
         valid_in = (req_total_reads != '0);
         whole_in = no_divide;
         hyper_in = (req_site_class != CLASS_HYPO);
         eos_in   = req_end_of_stream;
      end else if (state_ff == FRONT_DIVIDE) begin
         rem_in  = rem_ge ? READS_W'(rem_shift - {1'b0, total_ff}) : rem_shift[READS_W-1:0];
         quot_in = {quot_ff[FRAC_BITS-2:0], rem_ge};
         step_in = step_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      chrom_ff <= chrom_in;
      pos_ff   <= pos_in;
      total_ff <= total_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      step_ff  <= step_in;
      valid_ff <= valid_in;
      whole_ff <= whole_in;
      hyper_ff <= hyper_in;
      eos_ff   <= eos_in;
   end

   // A site with at least as many methylated reads as reads counts as exactly one.
   assign issue_frac       = whole_ff ? {1'b1, {FRAC_BITS{1'b0}}} : {1'b0, quot_ff};
   assign issue_site_valid = valid_ff;
   assign issue_chrom      = chrom_ff;
   assign issue_pos        = pos_ff;
   assign issue_hyper      = hyper_ff;
   assign issue_eos        = eos_ff;

endmodule

>>> rtl/core/mds_back.sv
// Back end: keeps the open run, decides per classified site whether it
// extends the run or closes it, and writes up to two domains per site into
// the response queue. Holds the two configuration registers.
module mds_back import mds_pkg::*; #(
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   item_empty,
   output logic                   item_pop,
   input  logic                   item_site_valid,
   input  logic [CHROM_W-1:0]     item_chrom,
   input  logic [POS_W-1:0]       item_pos,
   input  logic [FRAC_BITS:0]     item_frac,
   input  logic                   item_hyper,
   input  logic                   item_eos,
   input  logic                   out_full,
   output logic                   push_a,
   output mds_result_type         res_a,
   output logic                   push_b,
   output mds_result_type         res_b
);

   localparam int CMP_W = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;

   logic [POS_W-1:0]      desert_ff, desert_in;
   logic [SCORE_W-1:0]    min_score_ff, min_score_in;
   logic                  run_open_ff, run_open_in;
   logic [CHROM_W-1:0]    run_chrom_ff, run_chrom_in;
   logic [POS_W-1:0]      run_start_ff, run_start_in;
   logic [POS_W-1:0]      tail_pos_ff, tail_pos_in;
   logic                  run_is_hyper_ff, run_is_hyper_in;
   logic [COUNT_BITS-1:0] run_count_ff, run_count_in;
   logic [SCORE_W-1:0]    run_sum_ff, run_sum_in;

   logic                  take;
   logic                  extend;
   logic [POS_W-1:0]      gap;
   logic [SCORE_W:0]      sum_wide;
   logic [SCORE_W-1:0]    sum_next;
   logic [COUNT_BITS-1:0] count_next;
   logic                  emit_close;
   logic                  emit_flush;
   mds_result_type        res_close;
   mds_result_type        res_flush;

   // Builds one response from a run; the count saturates at the port width.
   function automatic mds_result_type make_result(
      input logic [CHROM_W-1:0]    chrom,
      input logic [POS_W-1:0]      start,
      input logic [POS_W-1:0]      last_pos,
      input logic [COUNT_BITS-1:0] count,
      input logic [SCORE_W-1:0]    sum
   );
      mds_result_type   r;
      logic [CMP_W-1:0] cnt;
      cnt           = CMP_W'(count);
      r.out_chrom   = chrom;
      r.start_pos   = start;
      r.stop_pos    = {1'b0, last_pos} + STOP_W'(1);
      r.site_count  = (cnt > CMP_W'(OUT_COUNT_MAX)) ? OUT_COUNT_W'(OUT_COUNT_MAX)
                                                     : cnt[OUT_COUNT_W-1:0];
      r.score       = sum;
      r.last_of_run = 1'b1;
      return r;
   endfunction

   // Configuration writes.
   always_comb begin
      desert_in    = desert_ff;
      min_score_in = min_score_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DESERT_LEN: desert_in    = csr_wdata[POS_W-1:0];
            CSR_MIN_SCORE:  min_score_in = csr_wdata[SCORE_W-1:0];
            default:        desert_in    = desert_ff;
         endcase
      end
   end

   assign take     = !item_empty && !out_full;
   assign item_pop = take;

   // Run extension test and the saturating count and sum.
   assign gap      = item_pos - tail_pos_ff;
   assign extend   = run_open_ff && (item_chrom == run_chrom_ff) &&
                     (item_pos >= tail_pos_ff) && (gap <= desert_ff) &&
                     (item_hyper == run_is_hyper_ff);
   assign sum_wide = {1'b0, run_sum_ff} + (SCORE_W + 1)'(item_frac);
   assign sum_next = sum_wide[SCORE_W] ? {SCORE_W{1'b1}} : sum_wide[SCORE_W-1:0];
   assign count_next = (run_count_ff == {COUNT_BITS{1'b1}}) ? run_count_ff
                                                            : run_count_ff + 1'b1;

   // Run state after the site, before the end-of-stream flush.
   always_comb begin
      run_open_in     = run_open_ff;
      run_chrom_in    = run_chrom_ff;
      run_start_in    = run_start_ff;
      tail_pos_in     = tail_pos_ff;
      run_is_hyper_in = run_is_hyper_ff;
      run_count_in    = run_count_ff;
      run_sum_in      = run_sum_ff;
      if (item_site_valid) begin
         run_open_in = 1'b1;
         tail_pos_in = item_pos;
         if (extend) begin
            run_count_in = count_next;
            run_sum_in   = sum_next;
         end else begin
            run_chrom_in    = item_chrom;
            run_start_in    = item_pos;
            run_is_hyper_in = item_hyper;
            run_count_in    = COUNT_BITS'(1);
            run_sum_in      = SCORE_W'(item_frac);
         end
      end
   end

   // Domains: the run that the site closes, then the run that the flush closes.
   assign emit_close = item_site_valid && !extend && run_open_ff && run_is_hyper_ff &&
                       (run_sum_ff >= min_score_ff);
   assign emit_flush = item_eos && run_open_in && run_is_hyper_in &&
                       (run_sum_in >= min_score_ff);

   always_comb begin
      res_close = make_result(run_chrom_ff, run_start_ff, tail_pos_ff,
                              run_count_ff, run_sum_ff);
      res_flush = make_result(run_chrom_in, run_start_in, tail_pos_in,
                              run_count_in, run_sum_in);
      res_close.last_of_run = !emit_flush;
      push_a = take && (emit_close || emit_flush);
      push_b = take && emit_close && emit_flush;
      res_a  = emit_close ? res_close : res_flush;
      res_b  = res_flush;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         desert_ff    <= DESERT_RESET;
         min_score_ff <= MIN_SCORE_RESET;
         run_open_ff  <= 1'b0;
      end else begin
         desert_ff    <= desert_in;
         min_score_ff <= min_score_in;
         if (take) begin
            run_open_ff <= run_open_in && !item_eos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         run_chrom_ff    <= run_chrom_in;
         run_start_ff    <= run_start_in;
         tail_pos_ff     <= tail_pos_in;
         run_is_hyper_ff <= run_is_hyper_in;
         run_count_ff    <= run_count_in;
         run_sum_ff      <= run_sum_in;
      end
   end

   // An end-of-stream site always leaves the block with no open run.
   a_flush_closes: assert property (@(posedge clock) disable iff (reset)
      (take && item_eos) |=> !run_open_ff)
      else $error("run still open after end of stream");

   // Every domain written in the first slot meets the score threshold.
   a_score_threshold: assert property (@(posedge clock) disable iff (reset)
      push_a |-> (res_a.score >= min_score_ff))
      else $error("domain below threshold written");

   // Every domain written in the first slot holds at least one site.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      push_a |-> (res_a.site_count != '0))
      else $error("domain with no sites written");

   // The domain ends after it starts.
   a_span_order: assert property (@(posedge clock) disable iff (reset)
      push_a |-> ({1'b0, res_a.start_pos} < res_a.stop_pos))
      else $error("domain stop not after start");

endmodule

>>> rtl/core/methylation_domain_segmenter.sv
// Methylation domain segmenter. Sites arrive sorted, one per request, and are
// grouped into runs of the hypo class or of the non-hypo classes; a chromosome
// change, a backward step or a gap above the desert limit also closes a run. A
// closed non-hypo run whose summed fraction reaches min_score is written to
// the response queue; end_of_stream flushes the open run, so one request can
// give two responses, the second carrying last_of_run. Sites with zero reads
// are dropped. The front end takes no new request until the last is issued;
// its divider yields one quotient bit per cycle and is skipped when the site
// fraction is one or the site has no reads. The back end handles one site per
// cycle while the response queue has two free entries. Configuration is to be
// written by the user only while the block is idle, which it does not enforce.
module methylation_domain_segmenter import mds_pkg::*; #(
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   push,
   output logic                   full,
   input  logic [CHROM_W-1:0]     req_chrom_id,
   input  logic [POS_W-1:0]       req_site_pos,
   input  logic [READS_W-1:0]     req_total_reads,
   input  logic [READS_W-1:0]     req_meth_reads,
   input  logic [CLASS_W-1:0]     req_site_class,
   input  logic                   req_end_of_stream,
   output logic                   empty,
   input  logic                   pop,
   output logic [CHROM_W-1:0]     rsp_out_chrom,
   output logic [POS_W-1:0]       rsp_start_pos,
   output logic [STOP_W-1:0]      rsp_stop_pos,
   output logic [OUT_COUNT_W-1:0] rsp_site_count,
   output logic [SCORE_W-1:0]     rsp_score,
   output logic                   rsp_last_of_run
);

   localparam int SITE_W = 1 + CHROM_W + POS_W + (FRAC_BITS + 1) + 1 + 1;
   localparam int RES_W  = $bits(mds_result_type);

   logic                 issue_push;
   logic                 issue_full;
   logic                 issue_site_valid;
   logic [CHROM_W-1:0]   issue_chrom;
   logic [POS_W-1:0]     issue_pos;
   logic [FRAC_BITS:0]   issue_frac;
   logic                 issue_hyper;
   logic                 issue_eos;
   logic [SITE_W-1:0]    issue_word;

   logic [SITE_W-1:0]    item_word;
   logic                 item_empty;
   logic                 item_pop;
   logic                 item_site_valid;
   logic [CHROM_W-1:0]   item_chrom;
   logic [POS_W-1:0]     item_pos;
   logic [FRAC_BITS:0]   item_frac;
   logic                 item_hyper;
   logic                 item_eos;

   logic                 out_full;
   logic                 push_a;
   logic                 push_b;
   mds_result_type       res_a;
   mds_result_type       res_b;
   logic [RES_W-1:0]     out_head;
   mds_result_type       rsp_head;

   mds_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (push),
      .req_full          (full),
      .req_chrom_id      (req_chrom_id),
      .req_site_pos      (req_site_pos),
      .req_total_reads   (req_total_reads),
      .req_meth_reads    (req_meth_reads),
      .req_site_class    (req_site_class),
      .req_end_of_stream (req_end_of_stream),
      .issue_push        (issue_push),
      .issue_full        (issue_full),
      .issue_site_valid  (issue_site_valid),
      .issue_chrom       (issue_chrom),
      .issue_pos         (issue_pos),
      .issue_frac        (issue_frac),
      .issue_hyper       (issue_hyper),
      .issue_eos         (issue_eos)
   );

   // Classified sites travel packed through the queue between the stages.
   assign issue_word = {issue_site_valid, issue_chrom, issue_pos, issue_frac,
                        issue_hyper, issue_eos};

   mds_queue #(
      .WIDTH (SITE_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_site_queue (
      .clock  (clock),
      .reset  (reset),
      .push_a (issue_push),
      .data_a (issue_word),
      .push_b (1'b0),
      .data_b (issue_word),
      .pop    (item_pop),
      .head   (item_word),
      .empty  (item_empty),
      .full   (issue_full)
   );

   assign {item_site_valid, item_chrom, item_pos, item_frac, item_hyper, item_eos} = item_word;

   mds_back #(
      .FRAC_BITS  (FRAC_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .item_empty      (item_empty),
      .item_pop        (item_pop),
      .item_site_valid (item_site_valid),
      .item_chrom      (item_chrom),
      .item_pos        (item_pos),
      .item_frac       (item_frac),
      .item_hyper      (item_hyper),
      .item_eos        (item_eos),
      .out_full        (out_full),
      .push_a          (push_a),
      .res_a           (res_a),
      .push_b          (push_b),
      .res_b           (res_b)
   );

   // Response queue; the back end may write two domains in one cycle.
   mds_queue #(
      .WIDTH (RES_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock  (clock),
      .reset  (reset),
      .push_a (push_a),
      .data_a (res_a),
      .push_b (push_b),
      .data_b (res_b),
      .pop    (pop),
      .head   (out_head),
      .empty  (empty),
      .full   (out_full)
   );

   assign rsp_head        = out_head;
   assign rsp_out_chrom   = rsp_head.out_chrom;
   assign rsp_start_pos   = rsp_head.start_pos;
   assign rsp_stop_pos    = rsp_head.stop_pos;
   assign rsp_site_count  = rsp_head.site_count;
   assign rsp_score       = rsp_head.score;
   assign rsp_last_of_run = rsp_head.last_of_run;

endmodule
